// ===== hw/rtl/fixed_point_alu_core_defines.svh =====
// Assertion macros for the fixed-point ALU core.
// Used by fixed_point_alu_core.sv; needs a clk and rst_n in scope.
`ifndef FIXED_POINT_ALU_CORE_DEFINES_SVH
`define FIXED_POINT_ALU_CORE_DEFINES_SVH

// Property checked on every clock edge outside reset
`define FPA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fixed_point_alu_core assertion failed");

// Property checked on every clock edge, also during reset
`define FPA_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("fixed_point_alu_core assertion failed");

`endif

// ===== hw/rtl/fpa_pkg.sv =====
// Package for the fixed-point ALU core: widths, mode and status codes,
// the pipeline item type and the saturating pack function. No dependencies.
package fpa_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 8;
    localparam int DIV_STEPS = WORD_BITS + FRAC_BITS;

    typedef enum logic [3:0] {
        MODE_ADD      = 4'd0,
        MODE_SUB      = 4'd1,
        MODE_MUL      = 4'd2,
        MODE_DIV      = 4'd3,
        MODE_GT       = 4'd4,
        MODE_LT       = 4'd5,
        MODE_GE       = 4'd6,
        MODE_LE       = 4'd7,
        MODE_EQ       = 4'd8,
        MODE_NE       = 4'd9,
        MODE_MIN      = 4'd10,
        MODE_MAX      = 4'd11,
        MODE_INC      = 4'd12,
        MODE_DEC      = 4'd13,
        MODE_TO_INT   = 4'd14,
        MODE_FROM_INT = 4'd15
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_OVF  = 2'd2
    } status_t;

    localparam logic [WORD_BITS-1:0] MAX_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] MIN_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};

    // One request as it moves down the pipeline
    typedef struct packed {
        mode_t                   mode;
        logic                    neg;      // result sign for mul/div
        logic                    a_neg;
        logic [WORD_BITS-1:0]    res;      // result of the simple modes
        logic                    cmp;
        status_t                 st;
        logic [2*WORD_BITS-1:0]  prod;     // magnitude product for mul
        logic [WORD_BITS-1:0]    d;        // divisor magnitude
        logic [WORD_BITS-1:0]    rem;      // partial remainder
        logic [DIV_STEPS-1:0]    num;      // numerator bits still to shift in
        logic [DIV_STEPS-1:0]    quo;      // quotient bits so far
    } item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] res;
        status_t              st;
    } packed_t;

    // Sign and magnitude to a word, saturating when out of range
    function automatic packed_t pack_sat(input logic neg,
                                         input logic [2*WORD_BITS-1:0] mag);
        packed_t p;
        p.st = ST_OK;
        if (neg) begin
            if (mag > {{WORD_BITS{1'b0}}, MIN_NEG}) begin
                p.res = MIN_NEG;
                p.st  = ST_OVF;
            end else begin
                p.res = -mag[WORD_BITS-1:0];
            end
        end else begin
            if (mag > {{WORD_BITS{1'b0}}, MAX_POS}) begin
                p.res = MAX_POS;
                p.st  = ST_OVF;
            end else begin
                p.res = mag[WORD_BITS-1:0];
            end
        end
        return p;
    endfunction

endpackage

// ===== hw/rtl/fixed_point_alu_core.sv =====
// Top level of the signed fixed-point ALU core.
// Depends on fpa_pkg, fpa_front, fpa_div_cell, fpa_back and the defines header.
//
// Accepts one request per clock and returns one result per request, in order.
// Data are signed Q23.8 in 32 bits. Every mode travels the same chain: an input
// stage (which also holds the magnitude multiplier), one divider cell per
// quotient bit, and an output register. The whole pipeline advances together and
// holds only while a result sits unaccepted at the output.
`include "fixed_point_alu_core_defines.svh"

module fixed_point_alu_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // operand_a[31:0], operand_b[63:32]
    input  logic [3:0]  s_axis_tuser,   // mode[3:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // result[31:0], compare_true[32], status[34:33]
);

    localparam int W = fpa_pkg::WORD_BITS;
    localparam int N = fpa_pkg::DIV_STEPS;

    logic            en;
    logic            chain_valid [0:N];
    fpa_pkg::item_t  chain_item  [0:N];
    logic [W-1:0]    result;
    logic            compare_true;
    logic [1:0]      status;

    // Global advance: stall only when the output holds an untaken result
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    fpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .mode      (fpa_pkg::mode_t'(s_axis_tuser)),
        .operand_a (s_axis_tdata[W-1:0]),
        .operand_b (s_axis_tdata[2*W-1:W]),
        .out_valid (chain_valid[0]),
        .out_item  (chain_item[0])
    );

    // Divider chain
    for (genvar i = 0; i < N; i++) begin : g_cell
        fpa_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_item   (chain_item[i]),
            .out_valid (chain_valid[i+1]),
            .out_item  (chain_item[i+1])
        );
    end

    fpa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (chain_valid[N]),
        .in_item      (chain_item[N]),
        .out_valid    (m_axis_tvalid),
        .result       (result),
        .compare_true (compare_true),
        .status       (status)
    );

    assign m_axis_tdata = {5'b0, status, compare_true, result};

    // Checks
    `FPA_ASSERT(a_cmp_clean, (m_axis_tvalid && compare_true) |-> (result == '0 && status == fpa_pkg::ST_OK))
    `FPA_ASSERT(a_ovf_sat, (m_axis_tvalid && status == fpa_pkg::ST_OVF) |-> (result == fpa_pkg::MAX_POS || result == fpa_pkg::MIN_NEG))
    `FPA_ASSERT(a_div0_sat, (m_axis_tvalid && status == fpa_pkg::ST_DIV0) |-> (result == fpa_pkg::MAX_POS || result == fpa_pkg::MIN_NEG))
    `FPA_ASSERT(a_no_code3, m_axis_tvalid |-> (status != 2'd3))

endmodule

// ===== hw/rtl/fpa_front.sv =====
// Input stage of the fixed-point ALU: simple modes, magnitude multiply,
// divider setup. Depends on fpa_pkg.
module fpa_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  fpa_pkg::mode_t                mode,
    input  logic [fpa_pkg::WORD_BITS-1:0] operand_a,
    input  logic [fpa_pkg::WORD_BITS-1:0] operand_b,
    output logic                          out_valid,
    output fpa_pkg::item_t                out_item
);

    localparam int W = fpa_pkg::WORD_BITS;
    localparam int F = fpa_pkg::FRAC_BITS;

    logic            valid_reg;
    fpa_pkg::item_t  item_reg;
    fpa_pkg::item_t  item_next;
    logic [W-1:0]    ma, mb, sum, dif;
    logic            lt, gt;
    logic [F:0]      top_bits;

    // Magnitudes, sum, difference and compares
    always_comb
    begin
        ma  = operand_a[W-1] ? -operand_a : operand_a;
        mb  = operand_b[W-1] ? -operand_b : operand_b;
        sum = operand_a + operand_b;
        dif = operand_a - operand_b;
        lt  = $signed(operand_a) < $signed(operand_b);
        gt  = $signed(operand_b) < $signed(operand_a);
        top_bits = operand_a[W-1:W-1-F];
    end

    // Simple mode results and setup of the long modes
    always_comb
    begin
        item_next       = '0;
        item_next.mode  = mode;
        item_next.neg   = operand_a[W-1] ^ operand_b[W-1];
        item_next.a_neg = operand_a[W-1];
        item_next.prod  = ma * mb;
        item_next.d     = mb;
        item_next.rem   = '0;
        item_next.num   = {ma, {F{1'b0}}};
        item_next.quo   = '0;
        item_next.st    = fpa_pkg::ST_OK;
        case (mode)
            fpa_pkg::MODE_ADD:
            begin
                item_next.res = sum;
                if (operand_a[W-1] == operand_b[W-1] && sum[W-1] != operand_a[W-1]) begin
                    item_next.res = operand_a[W-1] ? fpa_pkg::MIN_NEG : fpa_pkg::MAX_POS;
                    item_next.st  = fpa_pkg::ST_OVF;
                end
            end
            fpa_pkg::MODE_SUB:
            begin
                item_next.res = dif;
                if (operand_a[W-1] != operand_b[W-1] && dif[W-1] != operand_a[W-1]) begin
                    item_next.res = operand_a[W-1] ? fpa_pkg::MIN_NEG : fpa_pkg::MAX_POS;
                    item_next.st  = fpa_pkg::ST_OVF;
                end
            end
            fpa_pkg::MODE_GT:  item_next.cmp = gt;
            fpa_pkg::MODE_LT:  item_next.cmp = lt;
            fpa_pkg::MODE_GE:  item_next.cmp = !lt;
            fpa_pkg::MODE_LE:  item_next.cmp = !gt;
            fpa_pkg::MODE_EQ:  item_next.cmp = operand_a == operand_b;
            fpa_pkg::MODE_NE:  item_next.cmp = operand_a != operand_b;
            fpa_pkg::MODE_MIN: item_next.res = lt ? operand_a : operand_b;
            fpa_pkg::MODE_MAX: item_next.res = gt ? operand_a : operand_b;
            fpa_pkg::MODE_INC:
            begin
                if (operand_a == fpa_pkg::MAX_POS) begin
                    item_next.res = fpa_pkg::MAX_POS;
                    item_next.st  = fpa_pkg::ST_OVF;
                end else begin
                    item_next.res = operand_a + {{(W-1){1'b0}}, 1'b1};
                end
            end
            fpa_pkg::MODE_DEC:
            begin
                if (operand_a == fpa_pkg::MIN_NEG) begin
                    item_next.res = fpa_pkg::MIN_NEG;
                    item_next.st  = fpa_pkg::ST_OVF;
                end else begin
                    item_next.res = operand_a - {{(W-1){1'b0}}, 1'b1};
                end
            end
            fpa_pkg::MODE_TO_INT: item_next.res = $signed(operand_a) >>> F;
            fpa_pkg::MODE_FROM_INT:
            begin
                // fits when the top F+1 bits are all sign copies
                if (top_bits == '0 || top_bits == '1) begin
                    item_next.res = operand_a << F;
                end else begin
                    item_next.res = operand_a[W-1] ? fpa_pkg::MIN_NEG : fpa_pkg::MAX_POS;
                    item_next.st  = fpa_pkg::ST_OVF;
                end
            end
            default: item_next.res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== hw/rtl/fpa_div_cell.sv =====
// One cell of the divider chain: one restoring quotient bit per cell.
// Depends on fpa_pkg.
module fpa_div_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  fpa_pkg::item_t  in_item,
    output logic            out_valid,
    output fpa_pkg::item_t  out_item
);

    localparam int W = fpa_pkg::WORD_BITS;
    localparam int N = fpa_pkg::DIV_STEPS;

    logic            valid_reg;
    fpa_pkg::item_t  item_reg;
    fpa_pkg::item_t  item_next;
    logic [W:0]      trial;
    logic            take;

    // Shift in the next numerator bit, subtract when it fits
    always_comb
    begin
        trial          = {in_item.rem, in_item.num[N-1]};
        take           = trial >= {1'b0, in_item.d};
        item_next      = in_item;
        item_next.num  = {in_item.num[N-2:0], 1'b0};
        item_next.quo  = {in_item.quo[N-2:0], take};
        item_next.rem  = take ? (trial[W-1:0] - in_item.d) : trial[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== hw/rtl/fpa_back.sv =====
// Output stage of the fixed-point ALU: rounding and saturation of mul
// and div, final select, output register. Depends on fpa_pkg.
module fpa_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  fpa_pkg::item_t                in_item,
    output logic                          out_valid,
    output logic [fpa_pkg::WORD_BITS-1:0] result,
    output logic                          compare_true,
    output logic [1:0]                    status
);

    localparam int W = fpa_pkg::WORD_BITS;
    localparam int F = fpa_pkg::FRAC_BITS;
    localparam int N = fpa_pkg::DIV_STEPS;

    logic                   valid_reg;
    logic [W-1:0]           result_reg, result_next;
    logic                   cmp_reg, cmp_next;
    fpa_pkg::status_t       st_reg, st_next;
    logic [2*W:0]           prod_rnd;
    logic                   div_up;
    logic [N:0]             quo_rnd;
    fpa_pkg::packed_t       mul_p, div_p;

    // Round half away from zero on magnitudes, then saturate
    always_comb
    begin
        prod_rnd = {1'b0, in_item.prod} + {{(2*W+1-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
        mul_p    = fpa_pkg::pack_sat(in_item.neg, {{(F-1){1'b0}}, prod_rnd[2*W:F]});
        div_up   = {in_item.rem, 1'b0} >= {1'b0, in_item.d};
        quo_rnd  = {1'b0, in_item.quo} + {{N{1'b0}}, div_up};
        div_p    = fpa_pkg::pack_sat(in_item.neg, {{(2*W-N-1){1'b0}}, quo_rnd});
    end

    // Final select
    always_comb
    begin
        result_next = in_item.res;
        cmp_next    = in_item.cmp;
        st_next     = in_item.st;
        case (in_item.mode)
            fpa_pkg::MODE_MUL:
            begin
                result_next = mul_p.res;
                st_next     = mul_p.st;
            end
            fpa_pkg::MODE_DIV:
            begin
                if (in_item.d == '0) begin
                    result_next = in_item.a_neg ? fpa_pkg::MIN_NEG : fpa_pkg::MAX_POS;
                    st_next     = fpa_pkg::ST_DIV0;
                end else begin
                    result_next = div_p.res;
                    st_next     = div_p.st;
                end
            end
            default: result_next = in_item.res;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            result_reg <= result_next;
            cmp_reg    <= cmp_next;
            st_reg     <= st_next;
        end
    end

    assign out_valid    = valid_reg;
    assign result       = result_reg;
    assign compare_true = cmp_reg;
    assign status       = st_reg;

endmodule
